// File: rtl/core/spq_pkg.sv
// Shared types and codes for the stable priority queue.
// No dependencies; the top level, the cell and the testbench refer to it by scoped names.
package spq_pkg;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} spq_status_t;

	localparam logic OP_PUSH = 1'b0;
	localparam logic OP_POP  = 1'b1;

	// Per-cycle command broadcast to every cell of the chain.
	typedef struct packed {
		logic push;
		logic pop;
	} spq_ctrl_t;

endpackage

// File: rtl/core/spq_if.sv
// Valid/ready channel interfaces for the stable priority queue.
// Depends on nothing; used by the top level.
interface spq_cmd_if #(
	parameter int HANDLE_BITS = 8,
	parameter int RANK_BITS   = 2
) ();
	logic                   valid;
	logic                   ready;
	logic                   opcode;
	logic [HANDLE_BITS-1:0] item_handle;
	logic [RANK_BITS-1:0]   rank;

	modport source (output valid, opcode, item_handle, rank, input ready);
	modport sink   (input valid, opcode, item_handle, rank, output ready);
endinterface

interface spq_rsp_if #(
	parameter int HANDLE_BITS = 8,
	parameter int RANK_BITS   = 2,
	parameter int CNT_BITS    = 5
) ();
	logic                   valid;
	logic                   ready;
	logic [1:0]             status;
	logic [HANDLE_BITS-1:0] out_handle;
	logic [RANK_BITS-1:0]   out_rank;
	logic [CNT_BITS-1:0]    occupancy;

	modport source (output valid, status, out_handle, out_rank, occupancy, input ready);
	modport sink   (input valid, status, out_handle, out_rank, occupancy, output ready);
endinterface

// File: rtl/core/stable_priority_queue_top.sv
// Top level of the stable priority queue: command channel, response channel,
// fill counter and the chain of cells. Depends on spq_pkg, spq_if, spq_cell.
//
// Usage:
//   cmd carries one item per handshake: opcode (push or pop), item_handle
//   and rank. A push inserts the item behind every stored item of equal or
//   lower rank; a pop removes the head (lowest rank, oldest first).
//   rsp returns exactly one item per command: status (done, full, empty),
//   the popped handle and rank (zero otherwise) and occupancy after the op.
//   Latency: the response is valid the cycle after the command is taken.
//   Throughput: one command per cycle while the output register is free or
//   draining. Every cell compares its rank with the incoming rank in
//   parallel and shifts by one place in that same cycle.
//   Stall: the response sits in an output register; cmd.ready stays high
//   while that register is empty or being drained by rsp.ready, and drops
//   while a response waits, holding the queue state unchanged.
//   Reset (arst_n low): the queue is empty and no response is pending.
//   Cell contents are not cleared; only cells below the fill count are read.
//   Push on a full queue drops the item; pop on an empty queue leaves the
//   queue as it is. Both report their status in the response.
module stable_priority_queue_top #(
	parameter int DEPTH       = 16,
	parameter int HANDLE_BITS = 8,
	parameter int RANK_BITS   = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	spq_cmd_if.sink   cmd,
	spq_rsp_if.source rsp
);

	localparam int CNT_BITS = $clog2(DEPTH + 1);

	logic [CNT_BITS-1:0]    fill_q;
	logic                   rsp_valid_q;
	spq_pkg::spq_status_t   status_q;
	logic [HANDLE_BITS-1:0] out_handle_q;
	logic [RANK_BITS-1:0]   out_rank_q;
	logic [CNT_BITS-1:0]    occupancy_q;

	logic               accept;
	logic               is_full;
	logic               is_empty;
	spq_pkg::spq_ctrl_t ctrl;

	logic [HANDLE_BITS-1:0] c_handle [DEPTH];
	logic [RANK_BITS-1:0]   c_rank   [DEPTH];
	logic [DEPTH-1:0]       c_sel;

	// Take a command whenever the output register is free or draining.
	assign cmd.ready = !rsp_valid_q || rsp.ready;
	assign accept    = cmd.valid && cmd.ready;
	assign is_full   = fill_q == CNT_BITS'(DEPTH);
	assign is_empty  = fill_q == '0;

	assign ctrl.push = accept && (cmd.opcode == spq_pkg::OP_PUSH) && !is_full;
	assign ctrl.pop  = accept && (cmd.opcode == spq_pkg::OP_POP) && !is_empty;

	// Chain of cells: the head lives in cell 0. Pushes shift toward the tail
	// from the insertion point; pops shift everything one place toward the head.
	for (genvar k = 0; k < DEPTH; k++) begin : g_cell
		logic                   left_sel;
		logic [HANDLE_BITS-1:0] left_handle;
		logic [RANK_BITS-1:0]   left_rank;
		logic [HANDLE_BITS-1:0] right_handle;
		logic [RANK_BITS-1:0]   right_rank;

		if (k == 0) begin : g_head
			assign left_sel    = 1'b0;
			assign left_handle = '0;
			assign left_rank   = '0;
		end else begin : g_mid
			assign left_sel    = c_sel[k-1];
			assign left_handle = c_handle[k-1];
			assign left_rank   = c_rank[k-1];
		end

		if (k == DEPTH - 1) begin : g_tail
			// Hold the tail on a pop; its content is then past the fill count.
			assign right_handle = c_handle[k];
			assign right_rank   = c_rank[k];
		end else begin : g_body
			assign right_handle = c_handle[k+1];
			assign right_rank   = c_rank[k+1];
		end

		spq_cell #(
			.INDEX      (k),
			.HANDLE_BITS(HANDLE_BITS),
			.RANK_BITS  (RANK_BITS),
			.CNT_BITS   (CNT_BITS)
		) u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.fill        (fill_q),
			.new_handle  (cmd.item_handle),
			.new_rank    (cmd.rank),
			.left_sel    (left_sel),
			.left_handle (left_handle),
			.left_rank   (left_rank),
			.right_handle(right_handle),
			.right_rank  (right_rank),
			.sel         (c_sel[k]),
			.handle      (c_handle[k]),
			.rank        (c_rank[k])
		);
	end

	// Fill counter and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (ctrl.push) begin
				fill_q <= fill_q + CNT_BITS'(1);
			end else if (ctrl.pop) begin
				fill_q <= fill_q - CNT_BITS'(1);
			end
			if (accept) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// Response payload: capture the head on a pop, zeros otherwise.
	always_ff @(posedge clk) begin
		if (accept) begin
			out_handle_q <= '0;
			out_rank_q   <= '0;
			if (cmd.opcode == spq_pkg::OP_PUSH) begin
				status_q    <= is_full ? spq_pkg::ST_FULL : spq_pkg::ST_DONE;
				occupancy_q <= is_full ? fill_q : fill_q + CNT_BITS'(1);
			end else if (is_empty) begin
				status_q    <= spq_pkg::ST_EMPTY;
				occupancy_q <= fill_q;
			end else begin
				status_q     <= spq_pkg::ST_DONE;
				occupancy_q  <= fill_q - CNT_BITS'(1);
				out_handle_q <= c_handle[0];
				out_rank_q   <= c_rank[0];
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.status     = status_q;
	assign rsp.out_handle = out_handle_q;
	assign rsp.out_rank   = out_rank_q;
	assign rsp.occupancy  = occupancy_q;

	// The fill count never passes the number of cells.
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CNT_BITS'(DEPTH))
		else $error("fill count above depth");

	// A pop on an empty queue reports empty and keeps the count at zero.
	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.opcode == spq_pkg::OP_POP) && is_empty)
		|=> (rsp.status == spq_pkg::ST_EMPTY) && (fill_q == '0))
		else $error("pop on empty queue mishandled");

	// A rejected push reports full and leaves the fill count unchanged.
	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (cmd.opcode == spq_pkg::OP_PUSH) && is_full)
		|=> (rsp.status == spq_pkg::ST_FULL) && (fill_q == CNT_BITS'(DEPTH)))
		else $error("push on full queue changed state");

	// The reported occupancy matches the live count right after a command.
	a_occ_match: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (rsp.occupancy == fill_q))
		else $error("occupancy out of step with fill count");

endmodule

// File: rtl/core/spq_cell.sv
// One storage cell of the sorted shift chain: holds a handle and a rank.
// Depends on spq_pkg for the command struct.
module spq_cell #(
	parameter int INDEX       = 0,
	parameter int HANDLE_BITS = 8,
	parameter int RANK_BITS   = 2,
	parameter int CNT_BITS    = 5
) (
	input  logic                   clk,
	input  spq_pkg::spq_ctrl_t     ctrl,
	input  logic [CNT_BITS-1:0]    fill,
	input  logic [HANDLE_BITS-1:0] new_handle,
	input  logic [RANK_BITS-1:0]   new_rank,
	input  logic                   left_sel,
	input  logic [HANDLE_BITS-1:0] left_handle,
	input  logic [RANK_BITS-1:0]   left_rank,
	input  logic [HANDLE_BITS-1:0] right_handle,
	input  logic [RANK_BITS-1:0]   right_rank,
	output logic                   sel,
	output logic [HANDLE_BITS-1:0] handle,
	output logic [RANK_BITS-1:0]   rank
);

	logic [HANDLE_BITS-1:0] handle_q;
	logic [RANK_BITS-1:0]   rank_q;
	logic                   occupied;

	// Mark every cell from the insertion point up to the first free cell.
	assign occupied = fill > CNT_BITS'(INDEX);
	assign sel      = (occupied && (rank_q > new_rank)) || (fill == CNT_BITS'(INDEX));
	assign handle   = handle_q;
	assign rank     = rank_q;

	always_ff @(posedge clk) begin
		if (ctrl.push) begin
			if (sel && !left_sel) begin
				handle_q <= new_handle;
				rank_q   <= new_rank;
			end else if (left_sel) begin
				handle_q <= left_handle;
				rank_q   <= left_rank;
			end
		end else if (ctrl.pop) begin
			handle_q <= right_handle;
			rank_q   <= right_rank;
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for stable_priority_queue_top: directed and random
// push/pop items on the command channel, responses checked against a predictor.
// Depends on spq_pkg, spq_if and the RTL of the queue.
module tb;

	localparam int DEPTH       = 16;
	localparam int HANDLE_BITS = 8;
	localparam int RANK_BITS   = 2;
	localparam int CNT_BITS    = 5;
	// Cycles without any accepted item before the run is declared hung.
	localparam int STALL_LIMIT = 4000;
	localparam int MAX_REPORTS = 10;

	typedef struct {
		logic                   opcode;
		logic [HANDLE_BITS-1:0] item_handle;
		logic [RANK_BITS-1:0]   rank;
	} cmd_item_t;

	typedef struct {
		spq_pkg::spq_status_t   status;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [RANK_BITS-1:0]   out_rank;
		logic [CNT_BITS-1:0]    occupancy;
	} rsp_item_t;

	logic clk = 1'b0;
	logic arst_n;

	spq_cmd_if #(.HANDLE_BITS(HANDLE_BITS), .RANK_BITS(RANK_BITS)) cmd_ch ();
	spq_rsp_if #(.HANDLE_BITS(HANDLE_BITS), .RANK_BITS(RANK_BITS), .CNT_BITS(CNT_BITS)) rsp_ch ();

	stable_priority_queue_top #(
		.DEPTH(DEPTH),
		.HANDLE_BITS(HANDLE_BITS),
		.RANK_BITS(RANK_BITS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd_ch),
		.rsp(rsp_ch)
	);

	// Commands waiting to be driven, and responses the queue still owes us.
	cmd_item_t cmd_backlog[$];
	rsp_item_t owed_responses[$];

	// Shadow copy of the queue contents: cell 0 is the head.
	logic [HANDLE_BITS-1:0] shadow_handle [DEPTH];
	logic [RANK_BITS-1:0]   shadow_rank   [DEPTH];
	int                     shadow_count;

	int  send_idle_pct;
	int  recv_idle_pct;
	int  cmds_issued;
	int  rsp_checked;
	int  fault_count;
	int  quiet_cycles;
	logic cmd_taken;

	// 2 ns period: one delay high, one delay low.
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Apply one accepted command to the shadow queue and return the response
	// the block must produce for it. A push goes behind every stored item of
	// equal or lower rank, so equal ranks leave in arrival order.
	function automatic rsp_item_t predict_response(cmd_item_t c);
		rsp_item_t r;
		int        pos;
		bit        found;
		r.status     = spq_pkg::ST_DONE;
		r.out_handle = '0;
		r.out_rank   = '0;
		if (c.opcode == spq_pkg::OP_PUSH) begin
			if (shadow_count == DEPTH) begin
				// full: drop the item, leave the queue alone
				r.status = spq_pkg::ST_FULL;
			end else begin
				pos   = shadow_count;
				found = 1'b0;
				for (int k = 0; k < shadow_count; k++) begin
					if (!found && shadow_rank[k] > c.rank) begin
						pos   = k;
						found = 1'b1;
					end
				end
				for (int k = shadow_count; k > pos; k--) begin
					shadow_handle[k] = shadow_handle[k-1];
					shadow_rank[k]   = shadow_rank[k-1];
				end
				shadow_handle[pos] = c.item_handle;
				shadow_rank[pos]   = c.rank;
				shadow_count++;
			end
		end else if (shadow_count == 0) begin
			// empty: nothing to hand out
			r.status = spq_pkg::ST_EMPTY;
		end else begin
			r.out_handle = shadow_handle[0];
			r.out_rank   = shadow_rank[0];
			for (int k = 1; k < shadow_count; k++) begin
				shadow_handle[k-1] = shadow_handle[k];
				shadow_rank[k-1]   = shadow_rank[k];
			end
			shadow_count--;
		end
		r.occupancy = CNT_BITS'(shadow_count);
		return r;
	endfunction

	// Driver: change inputs on the falling edge only. Hold a presented item
	// until it is taken; otherwise either idle or advance to the next one.
	always @(negedge clk) begin
		cmd_item_t nxt;
		if (arst_n) begin
			if (!cmd_ch.valid || cmd_taken) begin
				if (cmd_backlog.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					nxt = cmd_backlog.pop_front();
					cmd_ch.valid       <= 1'b1;
					cmd_ch.opcode      <= nxt.opcode;
					cmd_ch.item_handle <= nxt.item_handle;
					cmd_ch.rank        <= nxt.rank;
				end else begin
					cmd_ch.valid <= 1'b0;
				end
			end
			rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: sample both channels on the rising edge. Check the response
	// before predicting the new command, so a response that shows up with
	// nothing owed cannot be matched against the item taken in this cycle.
	always @(posedge clk or negedge arst_n) begin
		cmd_item_t c;
		rsp_item_t want;
		bit        bad;
		if (!arst_n) begin
			cmd_taken <= 1'b0;
		end else begin
			cmd_taken <= cmd_ch.valid && cmd_ch.ready;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (owed_responses.size() == 0) begin
					fault_count++;
					if (fault_count <= MAX_REPORTS)
						$display("%0t: unexpected response status=%0d handle=%0h rank=%0d occ=%0d",
							$realtime, rsp_ch.status, rsp_ch.out_handle, rsp_ch.out_rank,
							rsp_ch.occupancy);
				end else begin
					want = owed_responses.pop_front();
					bad  = (rsp_ch.status !== want.status)
						|| (rsp_ch.out_handle !== want.out_handle)
						|| (rsp_ch.out_rank !== want.out_rank)
						|| (rsp_ch.occupancy !== want.occupancy);
					if (bad) begin
						fault_count++;
						if (fault_count <= MAX_REPORTS)
							$display({"%0t: response mismatch: want status=%0d handle=%0h ",
								"rank=%0d occ=%0d, got status=%0d handle=%0h rank=%0d occ=%0d"},
								$realtime, want.status, want.out_handle, want.out_rank,
								want.occupancy, rsp_ch.status, rsp_ch.out_handle,
								rsp_ch.out_rank, rsp_ch.occupancy);
					end
				end
				rsp_checked++;
			end
			if (cmd_ch.valid && cmd_ch.ready) begin
				c.opcode      = cmd_ch.opcode;
				c.item_handle = cmd_ch.item_handle;
				c.rank        = cmd_ch.rank;
				owed_responses.push_back(predict_response(c));
			end
		end
	end

	// Watchdog: end the run if neither channel moves an item for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("TEST FAILED");
				$finish;
			end
		end
	end

	task automatic add_cmd(input logic op, input int h, input int r);
		cmd_item_t c;
		c.opcode      = op;
		c.item_handle = HANDLE_BITS'(h);
		c.rank        = RANK_BITS'(r);
		cmd_backlog.push_back(c);
		cmds_issued++;
	endtask

	// Directed opening: pop on empty, fill to capacity with extreme handles
	// and repeated ranks, push twice into a full queue, then drain a few.
	// Pops carry nonzero handle fields and varied ranks, which the block must ignore.
	task automatic add_directed_cmds();
		add_cmd(spq_pkg::OP_POP, 8'hFF, 3);
		add_cmd(spq_pkg::OP_PUSH, 8'h00, 3);
		add_cmd(spq_pkg::OP_PUSH, 8'hFF, 0);
		add_cmd(spq_pkg::OP_PUSH, 8'hA5, 3);
		add_cmd(spq_pkg::OP_PUSH, 8'h5A, 0);
		add_cmd(spq_pkg::OP_PUSH, 8'h01, 1);
		add_cmd(spq_pkg::OP_PUSH, 8'h80, 2);
		add_cmd(spq_pkg::OP_PUSH, 8'h02, 1);
		add_cmd(spq_pkg::OP_PUSH, 8'h7F, 2);
		add_cmd(spq_pkg::OP_PUSH, 8'h10, 0);
		add_cmd(spq_pkg::OP_PUSH, 8'h20, 3);
		add_cmd(spq_pkg::OP_PUSH, 8'h03, 1);
		add_cmd(spq_pkg::OP_PUSH, 8'h40, 2);
		add_cmd(spq_pkg::OP_PUSH, 8'h11, 0);
		add_cmd(spq_pkg::OP_PUSH, 8'h21, 3);
		add_cmd(spq_pkg::OP_PUSH, 8'h04, 1);
		add_cmd(spq_pkg::OP_PUSH, 8'h41, 2);
		// queue is full now: both pushes must be dropped
		add_cmd(spq_pkg::OP_PUSH, 8'hEE, 0);
		add_cmd(spq_pkg::OP_PUSH, 8'h33, 3);
		for (int i = 0; i < 6; i++)
			add_cmd(spq_pkg::OP_POP, 8'hFF - i, i % 4);
	endtask

	// Random segments with a push bias of low, even or high, so the queue
	// swings between empty and full. Some segments narrow the rank range to
	// pile up equal ranks and exercise arrival order.
	task automatic add_random_cmds(input int count);
		int seg_len;
		int push_pct;
		int rank_lo;
		int rank_hi;
		while (count > 0) begin
			seg_len = $urandom_range(24, 1);
			case ($urandom_range(2))
				0: push_pct = 15;
				1: push_pct = 50;
				default: push_pct = 85;
			endcase
			rank_lo = $urandom_range(3);
			rank_hi = ($urandom_range(2) == 0) ? rank_lo : $urandom_range(3, rank_lo);
			for (int i = 0; i < seg_len && count > 0; i++) begin
				add_cmd(($urandom_range(99) < push_pct) ? spq_pkg::OP_PUSH : spq_pkg::OP_POP,
					$urandom_range(255), $urandom_range(rank_hi, rank_lo));
				count--;
			end
		end
	endtask

	// One phase: set the idle rates, queue the items, wait until every
	// response for them has been checked.
	task automatic run_phase(input int send_pct, input int recv_pct, input int n_random,
			input bit with_directed);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		if (with_directed)
			add_directed_cmds();
		add_random_cmds(n_random);
		wait (rsp_checked == cmds_issued);
	endtask

	initial begin
		// Drive every input to a known value from time zero.
		arst_n             = 1'b0;
		cmd_ch.valid       = 1'b0;
		cmd_ch.opcode      = spq_pkg::OP_PUSH;
		cmd_ch.item_handle = '0;
		cmd_ch.rank        = '0;
		rsp_ch.ready       = 1'b0;
		send_idle_pct      = 0;
		recv_idle_pct      = 0;
		cmds_issued        = 0;
		rsp_checked        = 0;
		fault_count        = 0;
		quiet_cycles       = 0;
		shadow_count       = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Receiver mostly stalling, then sender mostly idle, then full rate.
		run_phase(25, 81, 200, 1'b1);
		run_phase(81, 25, 240, 1'b0);
		run_phase(0, 0, 240, 1'b0);

		// Allow time for any stray response to show up.
		repeat (8) @(posedge clk);
		if (fault_count == 0 && owed_responses.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
